[hdl/ppp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared constants and types for the perspective point projection block.
// ----------------------------------------------------------------------------
package ppp_pkg;

  // Quotient bits produced by the divider, one per pipeline stage.
  localparam int DIV_STAGES = 31;
  localparam int NUM_W      = 49;  // numerator: magnitude * 2^17 + w
  localparam int DEN_W      = 33;  // divisor: 2 * w

  // Result codes.
  localparam logic [1:0] ST_VISIBLE = 2'd0;
  localparam logic [1:0] ST_BEHIND  = 2'd1;
  localparam logic [1:0] ST_MARGIN  = 2'd2;
  localparam logic [1:0] ST_OVF     = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_ROW0_XY  = 3'd0;
  localparam logic [2:0] REG_ROW0_ZW  = 3'd1;
  localparam logic [2:0] REG_ROW1_XY  = 3'd2;
  localparam logic [2:0] REG_ROW1_ZW  = 3'd3;
  localparam logic [2:0] REG_ROW3_XY  = 3'd4;
  localparam logic [2:0] REG_ROW3_ZW  = 3'd5;
  localparam logic [2:0] REG_WIDTH    = 3'd6;
  localparam logic [2:0] REG_HEIGHT   = 3'd7;

  localparam logic signed [31:0] BEHIND_LIMIT = 32'sd655;
  localparam logic signed [47:0] MARGIN_Q     = 48'sd131072000;  // 2000 * 2^16

  // Side information that travels beside the divider.
  typedef struct packed {
    logic        valid;
    logic        done;     // status already final (overflow or behind)
    logic [1:0]  status;
    logic [31:0] clip_w;
    logic        neg_x;
    logic        neg_y;
  } side_t;

endpackage

[hdl/ppp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider: two numerators over one shared divisor,
// one quotient bit per stage. The caller guarantees the quotient fits.
// ----------------------------------------------------------------------------
module ppp_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ppp_pkg::NUM_W-1:0]    num_x,
  input  logic [ppp_pkg::NUM_W-1:0]    num_y,
  input  logic [ppp_pkg::DEN_W-1:0]    den,
  output logic [ppp_pkg::DIV_STAGES-1:0] quo_x,
  output logic [ppp_pkg::DIV_STAGES-1:0] quo_y
);

  localparam int N = ppp_pkg::DIV_STAGES;

  logic [ppp_pkg::NUM_W-1:0]    rx [N];
  logic [ppp_pkg::NUM_W-1:0]    ry [N];
  logic [ppp_pkg::DEN_W-1:0]    dd [N];
  logic [N-1:0]                 qx [N];
  logic [N-1:0]                 qy [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [ppp_pkg::NUM_W-1:0] in_rx, in_ry;
    logic [ppp_pkg::DEN_W-1:0] in_d;
    logic [N-1:0]              in_qx, in_qy;
    logic [63:0]               shd;
    logic                      gx, gy;

    if (i == 0) begin : g_first
      assign in_rx = num_x;
      assign in_ry = num_y;
      assign in_d  = den;
      assign in_qx = '0;
      assign in_qy = '0;
    end else begin : g_next
      assign in_rx = rx[i-1];
      assign in_ry = ry[i-1];
      assign in_d  = dd[i-1];
      assign in_qx = qx[i-1];
      assign in_qy = qy[i-1];
    end

    // This stage decides quotient bit N-1-i.
    assign shd = 64'(in_d) << (N - 1 - i);
    assign gx  = 64'(in_rx) >= shd;
    assign gy  = 64'(in_ry) >= shd;

    always_ff @(posedge clk) begin
      if (en) begin
        rx[i] <= gx ? ppp_pkg::NUM_W'(64'(in_rx) - shd) : in_rx;
        ry[i] <= gy ? ppp_pkg::NUM_W'(64'(in_ry) - shd) : in_ry;
        dd[i] <= in_d;
        qx[i] <= in_qx | (N'(gx) << (N - 1 - i));
        qy[i] <= in_qy | (N'(gy) << (N - 1 - i));
      end
    end
  end

  assign quo_x = qx[N-1];
  assign quo_y = qy[N-1];

endmodule

[hdl/perspective_point_projection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_point_projection
// Projects one Q16.16 world point per cycle to clip, normalized and screen
// coordinates through a configured view matrix.
// ----------------------------------------------------------------------------
// Usage: points enter on the s_axis channel, x in the lowest 32 bits of
// s_tdata, then y, then z. Each point yields exactly one result item on the
// m_axis channel: m_tuser carries the status code and m_tdata carries
// screen x, screen y, clip w, ndc x and ndc y, lowest bits first.
// The matrix rows and viewport size are written over the APB port while
// the block is idle; they read back at the same addresses.
// From acceptance to the result, a point passes a multiplier stage, a row
// sum stage, a classification stage, 31 divider stages (one quotient bit
// each), a scale multiply stage and the output register. Throughput is
// one item per cycle, set by the fully pipelined divider. When the
// receiver stalls, the whole pipeline holds and s_tready drops; nothing
// is lost or repeated. Reset empties the pipeline, holds s_tready low,
// and returns the registers to an identity-free zero matrix and a
// 1920 by 1080 viewport.
// ----------------------------------------------------------------------------
module perspective_point_projection (
  input  logic          clk,
  input  logic          rst,
  // APB configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  // Point input
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,   // world_x, world_y, world_z
  // Result output
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [159:0]  m_tdata,   // screen_x, screen_y, clip_w, ndc_x, ndc_y
  output logic [1:0]    m_tuser    // status
);

  localparam int N = ppp_pkg::DIV_STAGES;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [63:0] row0_xy, row0_zw, row1_xy, row1_zw, row3_xy, row3_zw;
  logic [13:0] screen_width, screen_height;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      row0_xy       <= '0;
      row0_zw       <= '0;
      row1_xy       <= '0;
      row1_zw       <= '0;
      row3_xy       <= '0;
      row3_zw       <= '0;
      screen_width  <= 14'd1920;
      screen_height <= 14'd1080;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        ppp_pkg::REG_ROW0_XY: row0_xy       <= pwdata;
        ppp_pkg::REG_ROW0_ZW: row0_zw       <= pwdata;
        ppp_pkg::REG_ROW1_XY: row1_xy       <= pwdata;
        ppp_pkg::REG_ROW1_ZW: row1_zw       <= pwdata;
        ppp_pkg::REG_ROW3_XY: row3_xy       <= pwdata;
        ppp_pkg::REG_ROW3_ZW: row3_zw       <= pwdata;
        ppp_pkg::REG_WIDTH:   screen_width  <= pwdata[13:0];
        ppp_pkg::REG_HEIGHT:  screen_height <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ppp_pkg::REG_ROW0_XY: prdata = row0_xy;
      ppp_pkg::REG_ROW0_ZW: prdata = row0_zw;
      ppp_pkg::REG_ROW1_XY: prdata = row1_xy;
      ppp_pkg::REG_ROW1_ZW: prdata = row1_zw;
      ppp_pkg::REG_ROW3_XY: prdata = row3_xy;
      ppp_pkg::REG_ROW3_ZW: prdata = row3_zw;
      ppp_pkg::REG_WIDTH:   prdata = 64'(screen_width);
      ppp_pkg::REG_HEIGHT:  prdata = 64'(screen_height);
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together whenever the output
  // register is empty or being emptied. No item is taken during reset.
  // --------------------------------------------------------------------------
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  // --------------------------------------------------------------------------
  // Stage 1: the nine products of the three used matrix rows.
  // --------------------------------------------------------------------------
  logic signed [31:0] wx, wy, wz;
  assign wx = $signed(s_tdata[31:0]);
  assign wy = $signed(s_tdata[63:32]);
  assign wz = $signed(s_tdata[95:64]);

  logic               v1;
  logic signed [63:0] p0x, p0y, p0z, p1x, p1y, p1z, p3x, p3y, p3z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0x <= wx * $signed(row0_xy[31:0]);
      p0y <= wy * $signed(row0_xy[63:32]);
      p0z <= wz * $signed(row0_zw[31:0]);
      p1x <= wx * $signed(row1_xy[31:0]);
      p1y <= wy * $signed(row1_xy[63:32]);
      p1z <= wz * $signed(row1_zw[31:0]);
      p3x <= wx * $signed(row3_xy[31:0]);
      p3y <= wy * $signed(row3_xy[63:32]);
      p3z <= wz * $signed(row3_zw[31:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: exact Q32.32 row sums with the translation column, rounded to
  // Q16.16 with ties toward plus infinity.
  // --------------------------------------------------------------------------
  logic signed [66:0] sum_x, sum_y, sum_w;
  logic signed [66:0] rnd;
  assign rnd   = 67'sd32768;
  assign sum_x = 67'(p0x) + 67'(p0y) + 67'(p0z)
               + (67'($signed(row0_zw[63:32])) <<< 16) + rnd;
  assign sum_y = 67'(p1x) + 67'(p1y) + 67'(p1z)
               + (67'($signed(row1_zw[63:32])) <<< 16) + rnd;
  assign sum_w = 67'(p3x) + 67'(p3y) + 67'(p3z)
               + (67'($signed(row3_zw[63:32])) <<< 16) + rnd;

  logic               v2;
  logic signed [50:0] cx, cy, cw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx <= sum_x[66:16];
      cy <= sum_y[66:16];
      cw <= sum_w[66:16];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: range checks, behind-camera test and divider operands.
  // The ndc quotient is floor((|c| * 2^17 + w) / (2w)); it overflows when
  // the numerator reaches 2^31 times the divisor.
  // --------------------------------------------------------------------------
  logic               ovf_clip, behind, ovf_div;
  logic [31:0]        mag_x, mag_y;
  logic [ppp_pkg::NUM_W-1:0] num_x, num_y;
  logic [ppp_pkg::DEN_W-1:0] den;
  logic [63:0]               lim;

  assign ovf_clip = (cx[50:31] != {20{cx[31]}}) || (cy[50:31] != {20{cy[31]}})
                 || (cw[50:31] != {20{cw[31]}});
  assign behind   = $signed(cw[31:0]) <= ppp_pkg::BEHIND_LIMIT;
  assign mag_x    = cx[31] ? 32'(-{cx[31], cx[31:0]}) : cx[31:0];
  assign mag_y    = cy[31] ? 32'(-{cy[31], cy[31:0]}) : cy[31:0];
  assign num_x    = (ppp_pkg::NUM_W'(mag_x) << 17) + ppp_pkg::NUM_W'(cw[31:0]);
  assign num_y    = (ppp_pkg::NUM_W'(mag_y) << 17) + ppp_pkg::NUM_W'(cw[31:0]);
  assign den      = ppp_pkg::DEN_W'(cw[31:0]) << 1;
  assign lim      = 64'(den) << 31;
  assign ovf_div  = (64'(num_x) >= lim) || (64'(num_y) >= lim);

  ppp_pkg::side_t side3;
  logic [ppp_pkg::NUM_W-1:0] nx3, ny3;
  logic [ppp_pkg::DEN_W-1:0] d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      side3.valid <= 1'b0;
    end else if (en) begin
      side3.valid <= v2;
      side3.neg_x <= cx[31];
      side3.neg_y <= cy[31];
      nx3         <= num_x;
      ny3         <= num_y;
      d3          <= den;
      if (ovf_clip) begin
        side3.done   <= 1'b1;
        side3.status <= ppp_pkg::ST_OVF;
        side3.clip_w <= '0;
      end else if (behind) begin
        side3.done   <= 1'b1;
        side3.status <= ppp_pkg::ST_BEHIND;
        side3.clip_w <= cw[31:0];
      end else if (ovf_div) begin
        side3.done   <= 1'b1;
        side3.status <= ppp_pkg::ST_OVF;
        side3.clip_w <= cw[31:0];
      end else begin
        side3.done   <= 1'b0;
        side3.status <= ppp_pkg::ST_VISIBLE;
        side3.clip_w <= cw[31:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages, with the side information delayed alongside.
  // --------------------------------------------------------------------------
  logic [N-1:0] qx, qy;

  ppp_div u_div (
    .clk   (clk),
    .en    (en),
    .num_x (nx3),
    .num_y (ny3),
    .den   (d3),
    .quo_x (qx),
    .quo_y (qy)
  );

  ppp_pkg::side_t side_d [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        side_d[i].valid <= 1'b0;
      end
    end else if (en) begin
      side_d[0] <= side3;
      for (int i = 1; i < N; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  ppp_pkg::side_t sdv;
  assign sdv = side_d[N-1];

  // --------------------------------------------------------------------------
  // Scale stage: signed ndc and its product with the viewport size.
  // --------------------------------------------------------------------------
  logic signed [31:0] ndcx_c, ndcy_c;
  assign ndcx_c = sdv.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign ndcy_c = sdv.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  ppp_pkg::side_t     side_m;
  logic signed [31:0] ndcx_m, ndcy_m;
  logic signed [46:0] prod_x, prod_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_m.valid <= 1'b0;
    end else if (en) begin
      side_m <= sdv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ndcx_m <= ndcx_c;
      ndcy_m <= ndcy_c;
      prod_x <= 47'(ndcx_c) * 47'($signed({1'b0, screen_width}));
      prod_y <= 47'(ndcy_c) * 47'($signed({1'b0, screen_height}));
    end
  end

  // --------------------------------------------------------------------------
  // Output register: viewport mapping, margin test and saturation.
  //   sx = floor((W * 2^16 + ndc_x * W + 1) / 2)
  //   sy = floor((H * 2^16 - ndc_y * H + 1) / 2)
  // --------------------------------------------------------------------------
  logic signed [47:0] wq, hq, sx, sy;
  logic signed [47:0] tx, ty;
  logic               outside;
  logic signed [31:0] sx_sat, sy_sat;

  assign wq = 48'($signed({1'b0, screen_width})) <<< 16;
  assign hq = 48'($signed({1'b0, screen_height})) <<< 16;
  assign tx = wq + 48'(prod_x) + 48'sd1;
  assign ty = hq - 48'(prod_y) + 48'sd1;
  assign sx = tx >>> 1;
  assign sy = ty >>> 1;
  assign outside = (sx < -ppp_pkg::MARGIN_Q) || (sx > wq + ppp_pkg::MARGIN_Q)
                || (sy < -ppp_pkg::MARGIN_Q) || (sy > hq + ppp_pkg::MARGIN_Q);
  assign sx_sat = (sx[47:31] == {17{sx[47]}}) ? sx[31:0]
                : (sx[47] ? 32'sh80000000 : 32'sh7fffffff);
  assign sy_sat = (sy[47:31] == {17{sy[47]}}) ? sy[31:0]
                : (sy[47] ? 32'sh80000000 : 32'sh7fffffff);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= side_m.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_m.done) begin
        m_tuser <= side_m.status;
        m_tdata <= {64'd0, side_m.clip_w, 64'd0};
      end else begin
        m_tuser <= outside ? ppp_pkg::ST_MARGIN : ppp_pkg::ST_VISIBLE;
        m_tdata <= {ndcy_m, ndcx_m, side_m.clip_w, sy_sat, sx_sat};
      end
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the perspective point projection block.
// ----------------------------------------------------------------------------
// Points are streamed in with random gaps while the result side stalls at
// random. Every accepted point is projected by a bench-side model of the
// matrix transform, divide and viewport mapping. The projected result is
// queued and compared field by field with each result item that leaves the
// block. Several matrix and viewport settings are used, the extremes among
// them.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [31:0] clip_w;
    logic [31:0] ndc_x;
    logic [31:0] ndc_y;
  } projection_t;

  // Bench copy of the register file.
  logic [63:0] view_reg [8];
  int          error_count;

  function automatic longint floor_div2(longint v);
    return v >>> 1;
  endfunction

  // Exact dot product of one matrix row, rounded to Q16.16 with ties up.
  function automatic longint row_clip(logic [63:0] xy, logic [63:0] zw,
                                      longint x, longint y, longint z);
    longint acc_hi;
    longint prod [3];
    logic [63:0] frac_sum;
    acc_hi  = longint'($signed(zw[63:32]));
    prod[0] = x * longint'($signed(xy[31:0]));
    prod[1] = y * longint'($signed(xy[63:32]));
    prod[2] = z * longint'($signed(zw[31:0]));
    frac_sum = 0;
    for (int i = 0; i < 3; i++) begin
      acc_hi   += prod[i] >>> 16;
      frac_sum += prod[i] & 64'hFFFF;
    end
    return acc_hi + longint'((frac_sum + 64'h8000) >> 16);
  endfunction

  function automatic bit fits32(longint v);
    return v <= 64'sd2147483647 && v >= -64'sd2147483648;
  endfunction

  // Ratio (c << 16) / w rounded half away from zero; returns 0 on overflow.
  function automatic bit ndc_ratio(longint c, longint w, output longint q);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = (c < 0) ? -c : c;
    quo = ((mag << 17) + w) / (w << 1);
    q   = (c < 0) ? -longint'(quo) : longint'(quo);
    return quo <= 64'h7FFF_FFFF;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic projection_t project_point(logic [95:0] pt);
    projection_t r;
    longint x, y, z, cx, cy, cw, nx, ny, sx, sy, wd, ht;
    bit ok_x, ok_y;
    x  = longint'($signed(pt[31:0]));
    y  = longint'($signed(pt[63:32]));
    z  = longint'($signed(pt[95:64]));
    cx = row_clip(view_reg[ppp_pkg::REG_ROW0_XY], view_reg[ppp_pkg::REG_ROW0_ZW],
                  x, y, z);
    cy = row_clip(view_reg[ppp_pkg::REG_ROW1_XY], view_reg[ppp_pkg::REG_ROW1_ZW],
                  x, y, z);
    cw = row_clip(view_reg[ppp_pkg::REG_ROW3_XY], view_reg[ppp_pkg::REG_ROW3_ZW],
                  x, y, z);
    r = '{default: '0};
    if (!fits32(cx) || !fits32(cy) || !fits32(cw)) begin
      r.status = ppp_pkg::ST_OVF;
      return r;
    end
    r.clip_w = cw[31:0];
    if (cw <= 655) begin
      r.status = ppp_pkg::ST_BEHIND;
      return r;
    end
    ok_x = ndc_ratio(cx, cw, nx);
    ok_y = ndc_ratio(cy, cw, ny);
    if (!ok_x || !ok_y) begin
      r.status = ppp_pkg::ST_OVF;
      return r;
    end
    wd = longint'(view_reg[ppp_pkg::REG_WIDTH][13:0]);
    ht = longint'(view_reg[ppp_pkg::REG_HEIGHT][13:0]);
    sx = floor_div2(wd * 65536 + nx * wd + 1);
    sy = floor_div2(ht * 65536 - ny * ht + 1);
    if (sx < -64'sd131072000 || sx > (wd + 2000) * 65536 ||
        sy < -64'sd131072000 || sy > (ht + 2000) * 65536)
      r.status = ppp_pkg::ST_MARGIN;
    else
      r.status = ppp_pkg::ST_VISIBLE;
    r.screen_x = 32'(sat32(sx));
    r.screen_y = 32'(sat32(sy));
    r.ndc_x    = nx[31:0];
    r.ndc_y    = ny[31:0];
    return r;
  endfunction

  // Holds the projections still owed by the block, oldest first.
  class projection_board;
    projection_t pending [$];
    int          checked;

    function void note_point(logic [95:0] pt);
      pending.push_back(project_point(pt));
    endfunction

    function void check_result(logic [1:0] st, logic [159:0] d);
      projection_t e;
      if (pending.size() == 0) begin
        $error("result item arrived with no projection pending");
        error_count++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        error_count++;
      end
      if (d[31:0] !== e.screen_x) begin
        $error("screen_x: expected %h, got %h", e.screen_x, d[31:0]);
        error_count++;
      end
      if (d[63:32] !== e.screen_y) begin
        $error("screen_y: expected %h, got %h", e.screen_y, d[63:32]);
        error_count++;
      end
      if (d[95:64] !== e.clip_w) begin
        $error("clip_w: expected %h, got %h", e.clip_w, d[95:64]);
        error_count++;
      end
      if (d[127:96] !== e.ndc_x) begin
        $error("ndc_x: expected %h, got %h", e.ndc_x, d[127:96]);
        error_count++;
      end
      if (d[159:128] !== e.ndc_y) begin
        $error("ndc_y: expected %h, got %h", e.ndc_y, d[159:128]);
        error_count++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         psel, penable, pwrite;
  logic [5:0]   paddr;
  logic [63:0]  pwdata, prdata;
  logic         pready;
  logic         s_tvalid, s_tready;
  logic [95:0]  s_tdata;
  logic         m_tvalid, m_tready;
  logic [159:0] m_tdata;
  logic [1:0]   m_tuser;

  projection_board board;
  bit  calm;        // no idling on either side near the end of the run
  int  idle_cycles;
  int  points_sent;

  perspective_point_projection dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    s_tvalid = 0; s_tdata = 0; m_tready = 0;
  end

  // Result side: sample at the edge, then pick the next ready value.
  // A stall holds ready low until the stall counter runs out.
  always @(posedge clk) begin
    int stall;
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
      if (stall > 0) begin
        stall--;
        if (stall == 0) m_tready <= 1'b1;
      end else if (!calm && m_tready && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        stall = $urandom_range(1, 4);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no handshake on any side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Watchdog expired with %0d projections pending",
               board.pending.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    view_reg[idx] = (idx >= ppp_pkg::REG_WIDTH) ? {50'd0, val[13:0]} : val;
  endtask

  // Send one point, optionally preceded by a random burst of idle cycles.
  task automatic send_point(logic [95:0] pt);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= pt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_point(pt);
    points_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] q16(int v);
    return v << 16;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? $urandom() : -$urandom();
      default: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    endcase
  endfunction

  // A point near the camera frustum so that most results are visible.
  function automatic logic [95:0] rand_point();
    if ($urandom_range(0, 4) == 0)
      return {rand_word(), rand_word(), rand_word()};
    return {$signed($urandom_range(0, 30 << 16)) - (31 << 16),
            $signed($urandom_range(0, 20 << 16)) - (10 << 16),
            $signed($urandom_range(0, 20 << 16)) - (10 << 16)};
  endfunction

  // Perspective-like matrix: w = -z plus a random offset, small random mix.
  task automatic load_camera(int fx, int fy, logic [13:0] w, logic [13:0] h);
    write_reg(ppp_pkg::REG_ROW0_XY, {$urandom_range(0, 8191), q16(fx)});
    write_reg(ppp_pkg::REG_ROW0_ZW, {q16($urandom_range(0, 4)) - q16(2),
                                     32'($urandom_range(0, 65535))});
    write_reg(ppp_pkg::REG_ROW1_XY, {q16(fy), 32'($urandom_range(0, 8191))});
    write_reg(ppp_pkg::REG_ROW1_ZW, {32'($urandom()) >>> 14, 32'h0});
    write_reg(ppp_pkg::REG_ROW3_XY, {32'h0, 32'($urandom_range(0, 4095))});
    write_reg(ppp_pkg::REG_ROW3_ZW, {32'($urandom_range(0, 65535)), q16(-1)});
    write_reg(ppp_pkg::REG_WIDTH, 64'(w));
    write_reg(ppp_pkg::REG_HEIGHT, 64'(h));
  endtask

  initial begin
    board = new();
    calm = 0;
    error_count = 0;
    points_sent = 0;
    view_reg = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd1920, 64'd1080};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zero matrix at reset gives w = 0, which is behind the camera.
    send_point({32'h7FFF_FFFF, 32'h8000_0000, 32'h0});
    drain();

    // Identity-like camera, then the extremes of every field.
    load_camera(1, 1, 14'd1920, 14'd1080);
    send_point({q16(-5), 32'h0, 32'h0});                     // on axis
    send_point({q16(-5), q16(1), q16(1)});                   // visible
    send_point({q16(5), q16(1), q16(1)});                    // behind
    send_point({-32'sd655, 32'h0, 32'h0});                   // w near limit
    send_point({q16(-1), q16(9000), q16(9000)});             // outside margin
    send_point({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_point({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_point({32'hFFFF_F000, q16(30000), q16(30000)});     // ndc overflow
    send_point({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_point({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
    drain();

    // Extreme matrix entries force clip overflow; sizes at their extremes.
    write_reg(ppp_pkg::REG_ROW0_XY, 64'h7FFF_FFFF_8000_0000);
    write_reg(ppp_pkg::REG_ROW0_ZW, 64'h8000_0000_7FFF_FFFF);
    write_reg(ppp_pkg::REG_ROW1_XY, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(ppp_pkg::REG_ROW1_ZW, 64'h0000_0000_0000_0000);
    write_reg(ppp_pkg::REG_ROW3_XY, 64'h0000_0000_0001_0000);
    write_reg(ppp_pkg::REG_ROW3_ZW, 64'h7FFF_FFFF_0000_0000);
    write_reg(ppp_pkg::REG_WIDTH, 64'd8192);
    write_reg(ppp_pkg::REG_HEIGHT, 64'd0);
    send_point({32'h0, 32'h0, 32'h0});
    send_point({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_point({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_point({q16(-1), q16(1), q16(1)});
    drain();

    // Random phases over several viewport settings.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_camera(1, 1, 14'd1, 14'd1);
        1: load_camera(2, 3, 14'd8192, 14'd8192);
        2: load_camera(1, 2, 14'd1920, 14'd1080);
        default: load_camera($urandom_range(1, 4), $urandom_range(1, 4),
                             14'($urandom_range(1, 8192)),
                             14'($urandom_range(1, 8192)));
      endcase
      if (phase == 5) calm = 1;
      for (int n = 0; n < 190; n++) begin
        send_point(rand_point());
        // Once, in the third phase, wait until the block has delivered everything.
        if (phase == 2 && n == 100) begin
          s_tvalid <= 0;
          while (board.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d points and checked %0d results over several matrices,",
             points_sent, board.checked);
    $display("viewport sizes from 0 to 8192, with random stalls on both sides.");
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
